>>> hdl/piecewise_color_gradient_interpolator_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef PIECEWISE_COLOR_GRADIENT_INTERPOLATOR_MACROS_SVH
`define PIECEWISE_COLOR_GRADIENT_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset
`define PCGI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define PCGI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hdl/pcgi_pkg.sv
`default_nettype none
package pcgi_pkg;
    localparam int MAX_POINTS = 16;
    localparam int MAX_STOPS  = 16;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int ST_AW      = $clog2(MAX_STOPS);
    localparam int CNT_W      = 5;

    // shared divider: Q16 ratio numerator and position difference
    localparam int DIV_NUM_W  = 50;
    localparam int DIV_DEN_W  = 34;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

    localparam logic [1:0] OP_EVAL  = 2'd0;
    localparam logic [1:0] OP_POINT = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic CFG_POINT_COUNT = 1'b0;
    localparam logic CFG_STOP_COUNT  = 1'b1;

    localparam logic [16:0] Q16_ONE = 17'h10000;
endpackage
`default_nettype wire

>>> hdl/pcgi_div.sv
`default_nettype none
// Signed divide, truncating toward zero, one quotient bit per cycle.
module pcgi_div (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_start,
    input  wire signed [pcgi_pkg::DIV_NUM_W-1:0]   i_num,
    input  wire signed [pcgi_pkg::DIV_DEN_W-1:0]   i_den,
    output logic                                   o_done,
    output logic signed [pcgi_pkg::DIV_NUM_W-1:0]  o_quo
);
    localparam int NW = pcgi_pkg::DIV_NUM_W;
    localparam int DW = pcgi_pkg::DIV_DEN_W;

    logic                             r_busy;
    logic                             r_done;
    logic [pcgi_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [NW-1:0]                    r_q;
    logic [DW-1:0]                    r_rem;
    logic [DW-1:0]                    r_dmag;
    logic                             r_neg;

    logic [DW:0]   w_rem2;
    logic [DW+1:0] w_sub;
    logic          w_ge;

    // restoring step: bring down next dividend bit, try subtract
    assign w_rem2 = {r_rem, r_q[NW-1]};
    assign w_sub  = {1'b0, w_rem2} - {2'b00, r_dmag};
    assign w_ge   = !w_sub[DW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= pcgi_pkg::DIV_CNT_W'(NW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
            r_dmag <= i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
            r_rem  <= '0;
            r_neg  <= i_num[NW-1] ^ i_den[DW-1];
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], w_ge};
            r_rem <= w_ge ? w_sub[DW-1:0] : w_rem2[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule
`default_nettype wire

>>> hdl/piecewise_color_gradient_interpolator.sv
// Gradient lookup: an evaluate beat maps a signed Q16.16 sample to an ARGB color by
// interpolating between the breakpoints held in the point table, optionally reshaping
// the ratio through the easing-stop table; write beats load one table slot and give
// no result. One beat is handled at a time. An evaluate scans up to 14 breakpoints,
// reads the segment ends, and then loads the output register directly when the segment
// colors match or its positions coincide. Otherwise it runs the bit-serial ratio
// divide (50 quotient bits), then, when easing applies, scans up to 16 stops and
// forms the product and the second divide, then blends the channels and loads the
// output register once it is free. Its pace is set by the shared divider and the
// single read port of each table. Tables have no reset; read only written slots.
`default_nettype none
`include "piecewise_color_gradient_interpolator_macros.svh"
module piecewise_color_gradient_interpolator (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire        [1:0]  i_opcode,
    input  wire        [3:0]  i_slot,
    input  wire signed [31:0] i_sample,
    input  wire        [31:0] i_color_word,
    input  wire        [16:0] i_ease_position,
    input  wire signed [17:0] i_ease_value,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic       [31:0] o_color,
    input  wire               i_cfg_we,
    input  wire               i_cfg_idx,
    input  wire        [4:0]  i_cfg_data
);
    localparam int PAW = pcgi_pkg::PT_AW;
    localparam int SAW = pcgi_pkg::ST_AW;
    localparam int NW  = pcgi_pkg::DIV_NUM_W;
    localparam int DW  = pcgi_pkg::DIV_DEN_W;

    typedef enum logic [14:0] {
        S_IDLE   = 15'b000000000000001,
        S_SRD    = 15'b000000000000010,
        S_SCK    = 15'b000000000000100,
        S_LRD    = 15'b000000000001000,
        S_LCK    = 15'b000000000010000,
        S_HRD    = 15'b000000000100000,
        S_HCK    = 15'b000000001000000,
        S_DIV    = 15'b000000010000000,
        S_KRD    = 15'b000000100000000,
        S_KCK    = 15'b000001000000000,
        S_EMUL   = 15'b000010000000000,
        S_ESTART = 15'b000100000000000,
        S_EDIV   = 15'b001000000000000,
        S_CH     = 15'b010000000000000,
        S_OUT    = 15'b100000000000000
    } t_state;

    t_state r_state;

    // tables: point = {position, color}, stop = {position, value}
    logic [63:0] r_pmem [pcgi_pkg::MAX_POINTS];
    logic [34:0] r_smem [pcgi_pkg::MAX_STOPS];
    logic [63:0] r_prd;
    logic [34:0] r_sprd;

    logic [pcgi_pkg::CNT_W-1:0] r_pcnt, r_scnt;
    logic [PAW-1:0]             r_idx;
    logic [SAW-1:0]             r_kidx;
    logic signed [31:0]         r_v;
    logic signed [31:0]         r_plo;
    logic [31:0]                r_clo, r_chi;
    logic signed [NW-1:0]       r_r;
    logic [16:0]                r_splo, r_sphi;
    logic signed [17:0]         r_svlo, r_svhi;
    logic signed [36:0]         r_prod;
    logic [1:0]                 r_ch;
    logic [31:0]                r_res;
    logic                       r_ovalid;
    logic [31:0]                r_color;

    logic                       w_acc;
    logic [pcgi_pkg::CNT_W-1:0] w_npts, w_nst;
    logic [PAW-1:0]             w_pt_last;
    logic [SAW-1:0]             w_st_last;
    logic                       w_ease_en;
    logic signed [31:0]         w_pos;
    logic signed [32:0]         w_dv, w_dd;
    logic [16:0]                w_spos;
    logic signed [17:0]         w_sval;
    logic signed [18:0]         w_dval;
    logic signed [17:0]         w_dr;
    logic                       w_div_start;
    logic signed [NW-1:0]       w_num;
    logic signed [DW-1:0]       w_den;
    logic                       w_div_done;
    logic signed [NW-1:0]       w_quo;
    logic [7:0]                 w_cl, w_chb;
    logic signed [8:0]          w_cd;
    logic signed [59:0]         w_t;
    logic [7:0]                 w_chan;
    logic                       w_use_div;
    logic                       w_out_free;

    assign w_acc      = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign w_out_free = !r_ovalid || i_out_ready;

    // effective table sizes
    always_comb begin
        if (r_pcnt < 5'd2) begin
            w_npts = 5'd2;
        end else if (r_pcnt > 5'(pcgi_pkg::MAX_POINTS)) begin
            w_npts = 5'(pcgi_pkg::MAX_POINTS);
        end else begin
            w_npts = r_pcnt;
        end
        w_nst = (r_scnt > 5'(pcgi_pkg::MAX_STOPS)) ? 5'(pcgi_pkg::MAX_STOPS) : r_scnt;
    end
    assign w_pt_last = PAW'(w_npts - 5'd2);
    assign w_st_last = SAW'(w_nst - 5'd1);
    assign w_ease_en = (w_nst >= 5'd2);

    // table fields and differences
    assign w_pos  = $signed(r_prd[63:32]);
    assign w_dv   = $signed({r_v[31], r_v}) - $signed({r_plo[31], r_plo});
    assign w_dd   = $signed({w_pos[31], w_pos}) - $signed({r_plo[31], r_plo});
    assign w_spos = r_sprd[34:18];
    assign w_sval = $signed(r_sprd[17:0]);
    assign w_dval = $signed({r_svhi[17], r_svhi}) - $signed({r_svlo[17], r_svlo});
    assign w_dr   = $signed({1'b0, r_r[16:0]}) - $signed({1'b0, r_splo});
    assign w_use_div = (r_clo != r_prd[31:0]) && (r_plo != w_pos);

    // divider operands: ratio divide or easing divide
    always_comb begin
        if (r_state == S_ESTART) begin
            w_num = NW'(r_prod);
            w_den = $signed({{(DW-17){1'b0}}, 17'(r_sphi - r_splo)});
        end else begin
            w_num = $signed({w_dv[32], w_dv, 16'h0000});
            w_den = DW'(w_dd);
        end
        w_div_start = (r_state == S_ESTART) || ((r_state == S_HCK) && w_use_div);
    end

    pcgi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // one channel per cycle: t = cl*2^16 + r*(ch-cl), saturated
    assign w_cl  = r_clo[{r_ch, 3'b000} +: 8];
    assign w_chb = r_chi[{r_ch, 3'b000} +: 8];
    assign w_cd  = $signed({1'b0, w_chb}) - $signed({1'b0, w_cl});
    assign w_t   = $signed({36'h0, w_cl, 16'h0000})
                 + $signed({{(60-NW){r_r[NW-1]}}, r_r}) * w_cd;
    always_comb begin
        if (w_t[59]) begin
            w_chan = 8'h00;
        end else if (|w_t[58:24]) begin
            w_chan = 8'hFF;
        end else begin
            w_chan = w_t[23:16];
        end
    end

    // table writes and registered reads
    always_ff @(posedge i_clk) begin
        if (w_acc && i_opcode == pcgi_pkg::OP_POINT) begin
            r_pmem[i_slot[PAW-1:0]] <= {i_sample, i_color_word};
        end
        if (w_acc && i_opcode == pcgi_pkg::OP_STOP) begin
            r_smem[i_slot[SAW-1:0]] <= {i_ease_position, i_ease_value};
        end
        r_prd  <= r_pmem[r_idx];
        r_sprd <= r_smem[r_kidx];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt <= 5'd2;
            r_scnt <= 5'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pcgi_pkg::CFG_POINT_COUNT: r_pcnt <= i_cfg_data;
                pcgi_pkg::CFG_STOP_COUNT:  r_scnt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_ch     <= '0;
        end else begin
            // output register: load from S_OUT, drop when taken
            if (r_state == S_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && i_opcode == pcgi_pkg::OP_EVAL) begin
                        r_v <= i_sample;
                        if (w_npts == 5'd2) begin
                            r_idx   <= '0;
                            r_state <= S_LRD;
                        end else begin
                            r_idx   <= PAW'(1);
                            r_state <= S_SRD;
                        end
                    end
                end
                S_SRD: r_state <= S_SCK;
                // segment search
                S_SCK: begin
                    if (w_pos >= r_v) begin
                        r_idx   <= r_idx - 1'b1;
                        r_state <= S_LRD;
                    end else if (r_idx == w_pt_last) begin
                        r_state <= S_LRD;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SRD;
                    end
                end
                S_LRD: r_state <= S_LCK;
                S_LCK: begin
                    r_plo   <= w_pos;
                    r_clo   <= r_prd[31:0];
                    r_idx   <= r_idx + 1'b1;
                    r_state <= S_HRD;
                end
                S_HRD: r_state <= S_HCK;
                S_HCK: begin
                    r_chi <= r_prd[31:0];
                    if (r_clo == r_prd[31:0]) begin
                        r_res   <= r_clo;
                        r_state <= S_OUT;
                    end else if (r_plo == w_pos) begin
                        r_res   <= (r_v <= r_plo) ? r_clo : r_prd[31:0];
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_r <= w_quo;
                        r_ch <= '0;
                        if (w_ease_en && !w_quo[NW-1] &&
                            w_quo <= $signed(NW'(pcgi_pkg::Q16_ONE))) begin
                            r_kidx  <= '0;
                            r_state <= S_KRD;
                        end else begin
                            r_state <= S_CH;
                        end
                    end
                end
                S_KRD: r_state <= S_KCK;
                // easing stop search: first stop above the ratio
                S_KCK: begin
                    if (w_spos > r_r[16:0] && !r_r[NW-1] && !(|r_r[NW-2:17])) begin
                        if (r_kidx == '0) begin
                            r_r     <= NW'(w_sval);
                            r_state <= S_CH;
                        end else begin
                            r_sphi  <= w_spos;
                            r_svhi  <= w_sval;
                            r_state <= S_EMUL;
                        end
                    end else if (r_kidx == w_st_last) begin
                        r_r     <= NW'(w_sval);
                        r_state <= S_CH;
                    end else begin
                        r_splo  <= w_spos;
                        r_svlo  <= w_sval;
                        r_kidx  <= r_kidx + 1'b1;
                        r_state <= S_KRD;
                    end
                end
                S_EMUL: begin
                    r_prod  <= $signed({{18{w_dval[18]}}, w_dval})
                             * $signed({{19{w_dr[17]}}, w_dr});
                    r_state <= S_ESTART;
                end
                S_ESTART: r_state <= S_EDIV;
                S_EDIV: begin
                    if (w_div_done) begin
                        r_r     <= NW'(r_svlo) + w_quo;
                        r_state <= S_CH;
                    end
                end
                S_CH: begin
                    r_res[{r_ch, 3'b000} +: 8] <= w_chan;
                    r_ch <= r_ch + 1'b1;
                    if (r_ch == 2'd3) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_color  <= r_res;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_color     = r_color;

    // an evaluate beat always leaves idle
    `PCGI_ASSERT_NXT(a_eval_busy, w_acc && i_opcode == pcgi_pkg::OP_EVAL, r_state != S_IDLE)
    // divider completes only while the sequencer waits for it
    `PCGI_ASSERT_IMP(a_div_owner, w_div_done, r_state == S_DIV || r_state == S_EDIV)
    // a pending result is never overwritten
    `PCGI_ASSERT_NXT(a_out_hold, r_state == S_OUT && r_ovalid && !i_out_ready,
        r_state == S_OUT)
    // channel counter moves only during channel work
    `PCGI_ASSERT_IMP(a_ch_idle, r_ch != 2'd0, r_state == S_CH)
endmodule
`default_nettype wire

>>> bench/pcgi_gradient_checker.sv
`default_nettype none
module pcgi_gradient_checker (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_in_ready,
    input  wire        [1:0]  i_opcode,
    input  wire        [3:0]  i_slot,
    input  wire signed [31:0] i_sample,
    input  wire        [31:0] i_color_word,
    input  wire        [16:0] i_ease_position,
    input  wire signed [17:0] i_ease_value,
    input  wire               i_out_valid,
    input  wire               i_out_ready,
    input  wire        [31:0] i_color,
    input  wire               i_cfg_we,
    input  wire               i_cfg_idx,
    input  wire        [4:0]  i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE_Q16 = 65536;

    // shadow copy of the tables and registers
    logic [31:0]      pt_pos [pcgi_pkg::MAX_POINTS];
    logic [31:0]      pt_col [pcgi_pkg::MAX_POINTS];
    logic [16:0]      st_pos [pcgi_pkg::MAX_STOPS];
    logic [17:0]      st_val [pcgi_pkg::MAX_STOPS];
    logic [pcgi_pkg::CNT_W-1:0] pt_cnt;
    logic [pcgi_pkg::CNT_W-1:0] st_cnt;
    // expected colors, kept as a ring with running write and read counts
    logic [31:0]      exp_ring [64];
    int               exp_wr = 0;
    int               exp_rd = 0;
    int               errors = 0;

    assign o_fail_count = errors;
    assign o_pending    = exp_wr - exp_rd;

    task automatic report(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        errors++;
    endtask

    // reshape a Q16 ratio through the stop table
    function automatic longint eased_ratio(input longint r);
        int     n;
        int     k;
        longint plo, phi, vlo, vhi;
        n = (st_cnt > pcgi_pkg::MAX_STOPS) ? pcgi_pkg::MAX_STOPS : int'(st_cnt);
        if (n < 2 || r < 0 || r > ONE_Q16) return r;
        k = 0;
        while (k < n && longint'(st_pos[k]) <= r) k++;
        if (k == 0) return longint'($signed(st_val[0]));
        if (k == n) return longint'($signed(st_val[n-1]));
        plo = longint'(st_pos[k-1]);
        phi = longint'(st_pos[k]);
        vlo = longint'($signed(st_val[k-1]));
        vhi = longint'($signed(st_val[k]));
        return vlo + ((vhi - vlo) * (r - plo)) / (phi - plo);
    endfunction

    // one 8-bit channel, truncated and saturated
    function automatic logic [7:0] blend_channel(input logic [7:0] lo, input logic [7:0] hi,
                                                 input longint r);
        longint t;
        t = longint'(lo) * ONE_Q16 + r * (longint'(hi) - longint'(lo));
        if (t < 0) return 8'd0;
        if (t >= 256 * ONE_Q16) return 8'd255;
        return 8'(t / ONE_Q16);
    endfunction

    function automatic logic [31:0] gradient_color(input logic signed [31:0] sample);
        int          n;
        int          i;
        longint      v, plo, phi, r;
        logic [31:0] clo, chi;
        logic [31:0] res;
        v = longint'(sample);
        n = (pt_cnt < 2) ? 2 : ((pt_cnt > pcgi_pkg::MAX_POINTS) ? pcgi_pkg::MAX_POINTS
                                                                 : int'(pt_cnt));
        i = 1;
        while (i < n - 1 && longint'($signed(pt_pos[i])) < v) i++;
        clo = pt_col[i-1];
        chi = pt_col[i];
        if (clo == chi) return clo;
        plo = longint'($signed(pt_pos[i-1]));
        phi = longint'($signed(pt_pos[i]));
        if (plo == phi) return (v <= plo) ? clo : chi;
        r = eased_ratio(((v - plo) * ONE_Q16) / (phi - plo));
        for (int s = 0; s < 4; s++) begin
            res[s*8 +: 8] = blend_channel(clo[s*8 +: 8], chi[s*8 +: 8], r);
        end
        return res;
    endfunction

    // track config, input beats and output beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pt_cnt <= 5'd2;
            st_cnt <= 5'd0;
            exp_wr = 0;
            exp_rd = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == pcgi_pkg::CFG_POINT_COUNT) pt_cnt <= i_cfg_data;
                else                                        st_cnt <= i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                case (i_opcode)
                    pcgi_pkg::OP_EVAL: begin
                        exp_ring[6'(exp_wr)] = gradient_color(i_sample);
                        exp_wr++;
                    end
                    pcgi_pkg::OP_POINT: begin
                        pt_pos[i_slot] = i_sample;
                        pt_col[i_slot] = i_color_word;
                    end
                    pcgi_pkg::OP_STOP: begin
                        st_pos[i_slot] = i_ease_position;
                        st_val[i_slot] = i_ease_value;
                    end
                    default:  ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (exp_wr == exp_rd) begin
                    report($sformatf("unexpected result color=%08h", i_color));
                end else begin
                    if (i_color !== exp_ring[6'(exp_rd)])
                        report($sformatf("color got %08h exp %08h", i_color,
                                         exp_ring[6'(exp_rd)]));
                    exp_rd++;
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> bench/tb_piecewise_color_gradient_interpolator.sv
`default_nettype none
module tb_piecewise_color_gradient_interpolator;
    timeunit 1ns;
    timeprecision 1ps;

    // register settings of the random phases
    localparam logic [4:0] PTS [8] = '{5'd16, 5'd0, 5'd31, 5'd5, 5'd9, 5'd16, 5'd2, 5'd17};
    localparam logic [4:0] STS [8] = '{5'd16, 5'd1, 5'd31, 5'd2, 5'd17, 5'd0, 5'd3, 5'd16};

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic        [1:0]  i_opcode = pcgi_pkg::OP_EVAL;
    logic        [3:0]  i_slot = '0;
    logic signed [31:0] i_sample = '0;
    logic        [31:0] i_color_word = '0;
    logic        [16:0] i_ease_position = '0;
    logic signed [17:0] i_ease_value = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic        [31:0] o_color;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = pcgi_pkg::CFG_POINT_COUNT;
    logic        [4:0]  i_cfg_data = '0;
    int                 fail_count;
    int                 pending;

    // stretch controls, written by the stimulus process only
    logic               steady = 1'b0;
    logic               hold_go = 1'b0;

    // sorted point positions of the current phase
    int                 knot [pcgi_pkg::MAX_POINTS];

    piecewise_color_gradient_interpolator u_dut (.*);

    pcgi_gradient_checker u_chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_opcode, .i_slot,
        .i_sample, .i_color_word, .i_ease_position, .i_ease_value, .i_out_valid(o_out_valid),
        .i_out_ready, .i_color(o_color), .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #30ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: random back-pressure plus one long hold-off
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_out_ready <= steady || ($urandom_range(0, 99) >= 22);
            end
        end
    end

    // one input beat, called at a falling edge; valid stays up for the next beat
    task automatic send_beat(input logic [1:0] op, input logic [3:0] slot,
                             input logic [31:0] sample, input logic [31:0] color,
                             input logic [16:0] epos, input logic [17:0] eval_q);
        while (!steady && $urandom_range(0, 99) < 22) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_slot          <= slot;
        i_sample        <= sample;
        i_color_word    <= color;
        i_ease_position <= epos;
        i_ease_value    <= eval_q;
        // ready only moves at a rising edge, so its level here decides the next edge
        while (!o_in_ready) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_point(input int slot, input int pos, input logic [31:0] color);
        send_beat(pcgi_pkg::OP_POINT, 4'(slot), pos, color, 17'($urandom), 18'($urandom));
    endtask

    task automatic write_stop(input int slot, input int pos, input int val);
        send_beat(pcgi_pkg::OP_STOP, 4'(slot), $urandom, $urandom, 17'(pos), 18'(val));
    endtask

    task automatic evaluate(input int sample);
        send_beat(pcgi_pkg::OP_EVAL, 4'($urandom), sample, $urandom, 17'($urandom),
                  18'($urandom));
    endtask

    // drop valid, drain, let the block go idle, then write a register
    task automatic set_reg(input logic idx, input logic [4:0] val);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // reload both tables; mostly sorted, sometimes scrambled or with repeats
    task automatic load_tables(input bit scramble);
        int pos;
        int sp;
        logic [31:0] c;
        pos = int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        c   = $urandom;
        for (int s = 0; s < pcgi_pkg::MAX_POINTS; s++) begin
            knot[s] = pos;
            if ($urandom_range(0, 5) != 0) c = $urandom;
            write_point(s, scramble ? int'($urandom) : pos, c);
            pos += ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 32'h40000));
        end
        sp = $urandom_range(0, 4000);
        for (int s = 0; s < pcgi_pkg::MAX_STOPS; s++) begin
            write_stop(s, scramble ? int'($urandom_range(0, 65536)) : sp,
                       ($urandom_range(0, 3) == 0) ? int'($urandom)
                                                   : int'($urandom_range(0, 65536)));
            sp += int'($urandom_range(0, 8000));
            if (sp > 65536) sp = 65536;
        end
    endtask

    // random evaluates near the knots, with writes and noise mixed in
    task automatic run_items(input int count);
        int pick;
        for (int j = 0; j < count; j++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                evaluate(knot[$urandom_range(0, pcgi_pkg::MAX_POINTS-1)]
                         + int'($urandom_range(0, 32'h80000)) - 32'sh40000);
            else if (pick < 70)
                evaluate(knot[$urandom_range(0, pcgi_pkg::MAX_POINTS-1)]);
            else if (pick < 82)
                evaluate($urandom);
            else if (pick < 90)
                write_point($urandom_range(0, pcgi_pkg::MAX_POINTS-1),
                            knot[$urandom_range(0, 15)]
                            + int'($urandom_range(0, 32'h20000)), $urandom);
            else if (pick < 96)
                write_stop($urandom_range(0, pcgi_pkg::MAX_STOPS-1),
                           $urandom_range(0, 65536), $urandom);
            else
                send_beat(pcgi_pkg::OP_RSVD, 4'($urandom), $urandom, $urandom,
                          17'($urandom), 18'($urandom));
        end
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: extremes, coincident knots, equal colors, saturation, easing ends
        write_point(0, 32'sh8000_0000, 32'h0000_0000);
        write_point(1, 32'sh7FFF_FFFF, 32'hFFFF_FFFF);
        evaluate(32'sh8000_0000);
        evaluate(32'sh7FFF_FFFF);
        evaluate(0);
        evaluate(-1);
        send_beat(pcgi_pkg::OP_RSVD, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1FFFF,
                  18'h3FFFF);
        write_point(1, 32'sh8000_0000, 32'h1234_5678);
        evaluate(32'sh8000_0000);
        evaluate(0);
        write_point(1, 0, 32'h0000_0000);
        evaluate(5);
        write_point(0, 0, 32'h80FF_0080);
        write_point(1, 32'h10000, 32'h7F00_FF7F);
        evaluate(-32'sh10000);
        evaluate(32'h30000);
        evaluate(32'h8000);
        write_stop(0, 0, -131072);
        write_stop(1, 65536, 131071);
        set_reg(pcgi_pkg::CFG_STOP_COUNT, 5'd2);
        evaluate(32'h8000);
        evaluate(32'h10000);
        evaluate(0);
        write_stop(1, 65536, 0);
        evaluate(32'h4000);

        // random phases over several register settings
        for (int p = 0; p < 8; p++) begin
            set_reg(pcgi_pkg::CFG_POINT_COUNT, 5'd2);
            set_reg(pcgi_pkg::CFG_STOP_COUNT, 5'd0);
            load_tables(p == 6);
            set_reg(pcgi_pkg::CFG_POINT_COUNT, PTS[p]);
            set_reg(pcgi_pkg::CFG_STOP_COUNT, STS[p]);
            steady  <= (p == 3);
            hold_go <= (p == 2);
            run_items(184);
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (250) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+hdl
hdl/pcgi_pkg.sv
hdl/pcgi_div.sv
hdl/piecewise_color_gradient_interpolator.sv
bench/pcgi_gradient_checker.sv
bench/tb_piecewise_color_gradient_interpolator.sv
